// File: hdl/erf_pkg.sv
package erf_pkg;

    localparam int IN_W       = 24;
    localparam int OUT_W      = 18;
    localparam int Q          = 30;
    localparam int A_W        = 33;
    localparam int DEN_W      = 32;
    localparam int T_W        = 31;
    localparam int U_W        = 30;
    localparam int N_W        = 6;
    localparam int P_W        = 31;
    localparam int ACC_W      = 33;
    localparam int EXP_TERMS  = 12;
    localparam int POLY_STEPS = 5;

    localparam logic [P_W-1:0] ONE_Q   = {1'b1, {Q{1'b0}}};
    localparam logic [28:0]    C_P     = 29'd351748265;
    localparam logic [30:0]    C_LOG2E = 31'd1549082005;
    localparam logic [29:0]    C_LN2   = 30'd744261118;

    typedef struct packed {
        logic neg;
        logic sat;
    } flag_t;

    typedef struct packed {
        logic [U_W-1:0] u;
        logic [N_W-1:0] n;
        flag_t          flags;
    } exp_arg_t;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        exp_arg_t         arg;
    } front_t;

    typedef struct packed {
        logic [T_W-1:0] t;
        logic [P_W-1:0] e;
        flag_t          flags;
    } poly_in_t;

    function automatic logic signed [ACC_W-1:0] poly_coef(input logic [2:0] idx);
        logic signed [ACC_W-1:0] c;
        case (idx)
            3'd0:    c = 33'sd273621191;
            3'd1:    c = -33'sd305476044;
            3'd2:    c = 33'sd1526231383;
            3'd3:    c = -33'sd1560310108;
            3'd4:    c = 33'sd1139675401;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/erf_if.sv
interface erf_arg_if import erf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] x_value;

    modport source (output valid, output x_value, input ready);
    modport sink (input valid, input x_value, output ready);
endinterface

interface erf_res_if import erf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] erf_value;

    modport source (output valid, output erf_value, input ready);
    modport sink (input valid, input erf_value, output ready);
endinterface

// File: hdl/erf_front.sv
module erf_front import erf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [IN_W-1:0] x_value,
    output logic            out_valid,
    output front_t          out_data
);

    localparam int SH     = Q - FRAC_BITS;
    localparam int WIDE_W = (IN_W + SH > A_W) ? IN_W + SH : A_W;
    localparam int LIM_W  = IN_W + 3;
    localparam logic [LIM_W-1:0] LARGE_LIM = LIM_W'(6) << FRAC_BITS;

    logic [4:0]        v_reg;
    logic [IN_W-1:0]   mag;
    logic [WIDE_W-1:0] wide;

    logic [A_W-1:0]    a30_reg;
    flag_t             flg1_reg, flg2_reg, flg3_reg, flg4_reg, flg5_reg;
    logic [61:0]       pprod_reg;
    logic [59:0]       sq_reg;
    logic [DEN_W-1:0]  den3_reg, den4_reg, den5_reg;
    logic [60:0]       lf_reg;
    logic [36:0]       li_reg;
    logic [36:0]       z_next;
    logic [N_W-1:0]    n4_reg, n5_reg;
    logic [29:0]       zf_reg;
    logic [59:0]       up_reg;

    assign mag    = x_value[IN_W-1] ? (IN_W'(0) - x_value) : x_value;
    assign wide   = WIDE_W'(mag) << SH;
    assign z_next = li_reg + 37'(lf_reg[60:30]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            a30_reg        <= wide[A_W-1:0];
            flg1_reg.neg   <= x_value[IN_W-1];
            flg1_reg.sat   <= LIM_W'(mag) >= LARGE_LIM;

            pprod_reg <= 62'(C_P) * 62'(a30_reg);
            sq_reg    <= 60'(a30_reg[A_W-1:3]) * 60'(a30_reg[A_W-1:3]);
            flg2_reg  <= flg1_reg;

            den3_reg <= DEN_W'(ONE_Q) + pprod_reg[61:30];
            lf_reg   <= 61'(sq_reg[53:24]) * 61'(C_LOG2E);
            li_reg   <= 37'(sq_reg[59:54]) * 37'(C_LOG2E);
            flg3_reg <= flg2_reg;

            den4_reg <= den3_reg;
            n4_reg   <= z_next[35:30];
            zf_reg   <= z_next[29:0];
            flg4_reg <= flg3_reg;

            den5_reg <= den4_reg;
            n5_reg   <= n4_reg;
            up_reg   <= 60'(zf_reg) * 60'(C_LN2);
            flg5_reg <= flg4_reg;
        end
    end

    assign out_valid          = v_reg[4];
    assign out_data.den       = den5_reg;
    assign out_data.arg.u     = up_reg[59:30];
    assign out_data.arg.n     = n5_reg;
    assign out_data.arg.flags = flg5_reg;

endmodule

// File: hdl/erf_div.sv
module erf_div import erf_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  front_t         in_data,
    output logic           out_valid,
    output logic [T_W-1:0] t,
    output exp_arg_t       out_arg
);

    localparam logic [DEN_W-1:0] SEED = DEN_W'(1) << (Q - 1);

    logic [T_W-1:0]   v_reg;
    logic [DEN_W-1:0] rem_in [T_W];
    logic [DEN_W-1:0] rem_next [T_W];
    logic [DEN_W-1:0] rem_reg [T_W];
    logic [DEN_W-1:0] den_in [T_W];
    logic [DEN_W-1:0] den_reg [T_W];
    logic [T_W-1:0]   q_in [T_W];
    logic [T_W-1:0]   q_next [T_W];
    logic [T_W-1:0]   q_reg [T_W];
    logic [DEN_W:0]   trial [T_W];
    exp_arg_t         arg_in [T_W];
    exp_arg_t         arg_reg [T_W];

    always_comb begin
        rem_in[0] = SEED;
        den_in[0] = in_data.den;
        q_in[0]   = '0;
        arg_in[0] = in_data.arg;
        for (int k = 1; k < T_W; k++) begin
            rem_in[k] = rem_reg[k-1];
            den_in[k] = den_reg[k-1];
            q_in[k]   = q_reg[k-1];
            arg_in[k] = arg_reg[k-1];
        end
    end

    // One quotient bit per stage, most significant first.
    always_comb begin
        for (int k = 0; k < T_W; k++) begin
            trial[k]  = {rem_in[k], 1'b0};
            q_next[k] = q_in[k];
            if (trial[k] >= {1'b0, den_in[k]}) begin
                rem_next[k]            = DEN_W'(trial[k] - {1'b0, den_in[k]});
                q_next[k][T_W - 1 - k] = 1'b1;
            end
            else begin
                rem_next[k] = trial[k][DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else if (en) begin
            v_reg <= {v_reg[T_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < T_W; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in[k];
                q_reg[k]   <= q_next[k];
                arg_reg[k] <= arg_in[k];
            end
        end
    end

    assign out_valid = v_reg[T_W-1];
    assign t         = q_reg[T_W-1];
    assign out_arg   = arg_reg[T_W-1];

endmodule

// File: hdl/erf_exp.sv
module erf_exp import erf_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [T_W-1:0] t,
    input  exp_arg_t       in_arg,
    output logic           out_valid,
    output poly_in_t       out_data
);

    localparam int EXP_LAT = 2 * EXP_TERMS + 1;
    localparam int PR_W    = U_W + P_W;

    typedef struct packed {
        logic [T_W-1:0] t;
        exp_arg_t       arg;
    } exp_side_t;

    logic [EXP_LAT-1:0] v_reg;
    exp_side_t          side_in [EXP_LAT];
    exp_side_t          side_reg [EXP_LAT];
    logic [P_W-1:0]     recip [EXP_TERMS];
    logic [2:0]         rsh [EXP_TERMS];
    logic [P_W-1:0]     p_in [EXP_TERMS];
    logic [P_W-1:0]     q_val [EXP_TERMS];
    logic [PR_W-1:0]    prod_next [EXP_TERMS];
    logic [PR_W-1:0]    prod_reg [EXP_TERMS];
    logic [PR_W-1:0]    rprod_next [EXP_TERMS];
    logic [PR_W-1:0]    rprod_reg [EXP_TERMS];
    logic [P_W-1:0]     e_next;
    logic [P_W-1:0]     e_reg;

    // Division by the term index is a multiply by a rounded-up reciprocal.
    for (genvar j = 0; j < EXP_TERMS; j++) begin : g_recip
        localparam int K = EXP_TERMS - j;
        localparam int L = $clog2(K);
        localparam logic [63:0] M = ((64'd1 << (Q + L)) + 64'(K - 1)) / 64'(K);
        assign recip[j] = M[P_W-1:0];
        assign rsh[j]   = 3'(L);
    end

    always_comb begin
        side_in[0] = {t, in_arg};
        for (int i = 1; i < EXP_LAT; i++) begin
            side_in[i] = side_reg[i-1];
        end
        for (int j = 0; j < EXP_TERMS; j++) begin
            q_val[j] = P_W'(rprod_reg[j] >> (6'(Q) + 6'(rsh[j])));
        end
        p_in[0] = ONE_Q;
        for (int j = 1; j < EXP_TERMS; j++) begin
            p_in[j] = ONE_Q - q_val[j-1];
        end
        for (int j = 0; j < EXP_TERMS; j++) begin
            prod_next[j]  = PR_W'(side_in[2*j].arg.u) * PR_W'(p_in[j]);
            rprod_next[j] = PR_W'(prod_reg[j][59:30]) * PR_W'(recip[j]);
        end
        e_next = (ONE_Q - q_val[EXP_TERMS-1]) >> side_in[EXP_LAT-1].arg.n;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else if (en) begin
            v_reg <= {v_reg[EXP_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int i = 0; i < EXP_LAT; i++) begin
                side_reg[i] <= side_in[i];
            end
            for (int j = 0; j < EXP_TERMS; j++) begin
                prod_reg[j]  <= prod_next[j];
                rprod_reg[j] <= rprod_next[j];
            end
            e_reg <= e_next;
        end
    end

    assign out_valid      = v_reg[EXP_LAT-1];
    assign out_data.t     = side_reg[EXP_LAT-1].t;
    assign out_data.e     = e_reg;
    assign out_data.flags = side_reg[EXP_LAT-1].arg.flags;

endmodule

// File: hdl/erf_poly.sv
module erf_poly import erf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  poly_in_t         in_data,
    output logic             out_valid,
    output logic [OUT_W-1:0] erf_value
);

    localparam int POLY_LAT = 2 * POLY_STEPS + 3;
    localparam int MP_W     = ACC_W - 1 + T_W;
    localparam int TP_W     = ACC_W - 1 + P_W;
    localparam int RSH      = Q - FRAC_BITS;
    localparam int MAG_W    = FRAC_BITS + 1;
    localparam int EXT_W    = (MAG_W > OUT_W) ? MAG_W : OUT_W;
    localparam logic [P_W-1:0]   HALF    = P_W'(1) << (RSH - 1);
    localparam logic [MAG_W-1:0] ONE_OUT = MAG_W'(1) << FRAC_BITS;

    logic [POLY_LAT-1:0]     v_reg;
    poly_in_t                side_in [POLY_LAT];
    poly_in_t                side_reg [POLY_LAT];
    logic signed [ACC_W-1:0] acc_in [POLY_STEPS];
    logic [ACC_W-1:0]        amag [POLY_STEPS];
    logic                    sgn_reg [POLY_STEPS];
    logic [MP_W-1:0]         mprod_next [POLY_STEPS];
    logic [MP_W-1:0]         mprod_reg [POLY_STEPS];
    logic [ACC_W-1:0]        sr [POLY_STEPS];
    logic signed [ACC_W-1:0] acc_next [POLY_STEPS];
    logic signed [ACC_W-1:0] acc_reg [POLY_STEPS];
    logic [ACC_W-2:0]        poly_val;
    logic [TP_W-1:0]         tprod_reg;
    logic [TP_W-Q-1:0]       term;
    logic [P_W-1:0]          r_next;
    logic [P_W-1:0]          r_reg;
    logic [P_W-1:0]          rnd;
    logic [P_W-1:0]          shr;
    logic [MAG_W-1:0]        mag;
    logic [EXT_W-1:0]        ext;
    logic [OUT_W-1:0]        erf_next;
    logic [OUT_W-1:0]        erf_reg;

    always_comb begin
        side_in[0] = in_data;
        for (int i = 1; i < POLY_LAT; i++) begin
            side_in[i] = side_reg[i-1];
        end

        acc_in[0] = poly_coef(3'(POLY_STEPS - 1));
        for (int s = 1; s < POLY_STEPS; s++) begin
            acc_in[s] = acc_reg[s-1];
        end

        // Horner steps in sign-magnitude, each product truncated toward zero.
        for (int s = 0; s < POLY_STEPS; s++) begin
            amag[s]       = acc_in[s][ACC_W-1] ? (ACC_W'(0) - acc_in[s]) : acc_in[s];
            mprod_next[s] = MP_W'(amag[s][ACC_W-2:0]) * MP_W'(side_in[2*s].t);
            sr[s]         = sgn_reg[s] ? (ACC_W'(0) - mprod_reg[s][MP_W-1:Q])
                                       : mprod_reg[s][MP_W-1:Q];
            if (s < POLY_STEPS - 1) begin
                acc_next[s] = poly_coef(3'(POLY_STEPS - 2 - s)) + $signed(sr[s]);
            end
            else begin
                acc_next[s] = $signed(sr[s]);
            end
        end

        poly_val = acc_reg[POLY_STEPS-1][ACC_W-1] ? '0 : acc_reg[POLY_STEPS-1][ACC_W-2:0];

        term   = tprod_reg[TP_W-1:Q];
        r_next = (term >= (TP_W-Q)'(ONE_Q)) ? '0 : (ONE_Q - P_W'(term));

        rnd = r_reg + HALF;
        shr = rnd >> RSH;
        mag = shr[MAG_W-1:0];
        if (side_reg[POLY_LAT-2].flags.sat || mag > ONE_OUT) begin
            mag = ONE_OUT;
        end
        ext = EXT_W'(mag);
        if (side_reg[POLY_LAT-2].flags.neg) begin
            ext = EXT_W'(0) - ext;
        end
        erf_next = ext[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else if (en) begin
            v_reg <= {v_reg[POLY_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int i = 0; i < POLY_LAT; i++) begin
                side_reg[i] <= side_in[i];
            end
            for (int s = 0; s < POLY_STEPS; s++) begin
                sgn_reg[s]   <= acc_in[s][ACC_W-1];
                mprod_reg[s] <= mprod_next[s];
                acc_reg[s]   <= acc_next[s];
            end
            tprod_reg <= TP_W'(poly_val) * TP_W'(side_in[2*POLY_STEPS].e);
            r_reg     <= r_next;
            erf_reg   <= erf_next;
        end
    end

    assign out_valid = v_reg[POLY_LAT-1];
    assign erf_value = erf_reg;

endmodule

// File: hdl/erf_approximation_unit.sv
// Error function unit, erf(x) by the Abramowitz-Stegun rational approximation.
// Requests arrive on the arg channel: x_value is signed with FRAC_BITS fraction
// bits (Q7.16 by default). Results leave on the res channel: erf_value is
// signed with FRAC_BITS fraction bits and always lies within plus or minus one.
// Both channels take a transfer on a clock edge where valid and ready are high.
// The unit is a 74-stage pipeline followed by an output register. One request
// is taken every cycle while arg.ready is high; the depth comes mostly from the
// one-bit-per-stage reciprocal divider and the twelve multiply stages pairs of
// the exponential series.
// When res is stalled the held result stays in the output register while the
// pipeline keeps filling any empty slots; arg.ready falls only when the last
// pipeline stage and the output register are both full. Nothing is dropped or
// repeated across a stall. Reset empties the pipeline and the output register;
// the unit keeps no other state.
module erf_approximation_unit import erf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input logic      clk,
    input logic      rst_n,
    erf_arg_if.sink  arg,
    erf_res_if.source res
);

    localparam int ONE_LIM = 1 << FRAC_BITS;

    logic             en;
    logic             out_load;
    logic             last_valid;
    logic             front_valid;
    logic             div_valid;
    logic             exp_valid;
    front_t           front_data;
    logic [T_W-1:0]   div_t;
    exp_arg_t         div_arg;
    poly_in_t         exp_data;
    logic [OUT_W-1:0] poly_value;
    logic             out_valid_reg;
    logic [OUT_W-1:0] erf_value_reg;

    assign out_load  = !out_valid_reg || res.ready;
    assign en        = out_load || !last_valid;
    assign arg.ready = en;

    erf_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (arg.valid),
        .x_value   (arg.x_value),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    erf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .t         (div_t),
        .out_arg   (div_arg)
    );

    erf_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .t         (div_t),
        .in_arg    (div_arg),
        .out_valid (exp_valid),
        .out_data  (exp_data)
    );

    erf_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (exp_valid),
        .in_data   (exp_data),
        .out_valid (last_valid),
        .erf_value (poly_value)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load) begin
            out_valid_reg <= last_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (out_load && last_valid) begin
            erf_value_reg <= poly_value;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.erf_value = erf_value_reg;

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !arg.ready |-> (last_valid && res.valid && !res.ready))
        else $error("Request port stalled while the pipeline had room.");

    a_drain_empties_output: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && !last_valid) |=> !res.valid)
        else $error("Output register kept a result after it was taken.");

    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (FRAC_BITS > OUT_W - 2 ||
                       ($signed(res.erf_value) <= ONE_LIM &&
                        $signed(res.erf_value) >= -ONE_LIM)))
        else $error("Result magnitude exceeds one.");

endmodule

// File: tb/sv/tb_erf_approximation_unit.sv
`timescale 1ns / 1ps

module tb_erf_approximation_unit;
    import erf_pkg::*;

    localparam int FRAC = 16;
    localparam int PIPE_LAT = 75;
    localparam longint unsigned ONE30 = 64'd1 << 30;
    localparam longint unsigned MASK30 = ONE30 - 64'd1;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    logic clk;
    logic rst_n;

    erf_arg_if arg ();
    erf_res_if res ();

    erf_approximation_unit #(.FRAC_BITS(FRAC)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .arg   (arg),
        .res   (res)
    );

    logic signed [IN_W-1:0]  pending_x[$];
    logic signed [OUT_W-1:0] erf_expected_q[$];
    idle_mode_t              mode;
    int                      hold_off;
    int                      errors;
    int                      checked;
    int                      saturated;
    logic                    arg_taken;

    function automatic longint mul_signed_q30(input longint a, input longint unsigned b);
        longint unsigned m;
        longint unsigned r;
        m = (a < 0) ? longint'(-a) : longint'(a);
        r = (m * b) >> 30;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned exp_neg_q30(input longint unsigned y);
        longint unsigned yi;
        longint unsigned z;
        longint unsigned n;
        longint unsigned u;
        longint unsigned p;
        yi = y >> 30;
        z = yi * 64'd1549082005 + (((y & MASK30) * 64'd1549082005) >> 30);
        n = z >> 30;
        u = ((z & MASK30) * 64'd744261118) >> 30;
        p = ONE30;
        for (int k = 12; k >= 1; k--)
            p = ONE30 - ((u * p) >> 30) / longint'(k);
        if (n >= 62)
            return 64'd0;
        return p >> n;
    endfunction

    function automatic logic signed [OUT_W-1:0] erf_of(input logic signed [IN_W-1:0] x);
        logic                 neg;
        longint unsigned      mag;
        longint unsigned      a30;
        longint unsigned      den;
        longint unsigned      t;
        longint unsigned      poly;
        longint unsigned      a27;
        longint unsigned      term;
        longint unsigned      r;
        longint unsigned      rv;
        longint               acc;
        longint               coefs[5];
        coefs = '{273621191, -305476044, 1526231383, -1560310108, 1139675401};
        neg = x[IN_W-1];
        mag = neg ? ((64'd1 << IN_W) - longint'({1'b0, x})) : longint'({1'b0, x});
        mag = mag & ((64'd1 << IN_W) - 1) | (neg && mag == 0 ? 64'd0 : 64'd0);
        if (neg && x == {1'b1, {(IN_W-1){1'b0}}})
            mag = 64'd1 << (IN_W - 1);
        a30 = mag << (30 - FRAC);
        if (a30 >= 6 * ONE30) begin
            rv = 64'd1 << FRAC;
        end else begin
            den = ONE30 + ((64'd351748265 * a30) >> 30);
            t = (ONE30 << 30) / den;
            acc = coefs[4];
            for (int i = 3; i >= 0; i--)
                acc = coefs[i] + mul_signed_q30(acc, t);
            acc = mul_signed_q30(acc, t);
            poly = (acc < 0) ? 64'd0 : longint'(acc);
            a27 = a30 >> 3;
            term = (poly * exp_neg_q30((a27 * a27) >> 24)) >> 30;
            r = (term >= ONE30) ? 64'd0 : ONE30 - term;
            rv = (r + (64'd1 << (30 - FRAC - 1))) >> (30 - FRAC);
            if (rv > (64'd1 << FRAC))
                rv = 64'd1 << FRAC;
        end
        if (neg)
            rv = 64'd0 - rv;
        return rv[OUT_W-1:0];
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tb_erf_approximation_unit: errors");
        $finish;
    end

    // Requests are taken and results are checked at the rising edge.
    always @(posedge clk)
    begin
        arg_taken <= arg.valid && arg.ready;
        if (rst_n && arg.valid && arg.ready)
            erf_expected_q.push_back(erf_of(arg.x_value));
        if (rst_n && res.valid && res.ready) begin
            if (erf_expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, res.erf_value);
            end else begin
                if (res.erf_value !== erf_expected_q[0]) begin
                    errors++;
                    $display("%0t: erf mismatch, expected %0d, actual %0d",
                             $time, erf_expected_q[0], res.erf_value);
                end
                if (erf_expected_q[0] == 18'sd65536 || erf_expected_q[0] == -18'sd65536)
                    saturated++;
                void'(erf_expected_q.pop_front());
                checked++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (arg_taken || !arg.valid) begin
            if (rst_n && pending_x.size() > 0 &&
                !((mode == IDLE_SRC && $urandom_range(99) < 52) ||
                  (mode == IDLE_BOTH && $urandom_range(99) < 32))) begin
                arg.valid   <= 1'b1;
                arg.x_value <= pending_x.pop_front();
            end else begin
                arg.valid <= 1'b0;
            end
        end
    end

    // The long hold-off is counted here so the sender keeps offering requests.
    always @(negedge clk)
    begin
        if (hold_off > 0) begin
            res.ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end else if ((mode == IDLE_SNK && $urandom_range(99) < 52) ||
                     (mode == IDLE_BOTH && $urandom_range(99) < 32)) begin
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    initial
    begin
        logic signed [IN_W-1:0] dir_x[$];
        int                     x_lo;
        arg.valid   = 1'b0;
        arg.x_value = '0;
        res.ready   = 1'b0;
        rst_n       = 1'b0;
        mode        = IDLE_NONE;
        hold_off    = 0;
        errors      = 0;
        checked     = 0;
        saturated   = 0;
        arg_taken   = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_x = '{24'sd0, 24'sd1, -24'sd1, 24'sd8388607, 24'sh800000,
                  24'sd393216, -24'sd393216, 24'sd393215, -24'sd393215,
                  24'sd65536, -24'sd65536, 24'sd32768, -24'sd32768,
                  24'sd131072, -24'sd131072, 24'sd196608, 24'sd262144,
                  24'sd16, -24'sd16, 24'sd8388606, -24'sd8388607,
                  24'sd327680, -24'sd6554, 24'sd100000};
        foreach (dir_x[i])
            pending_x.push_back(dir_x[i]);

        for (int ph = 0; ph < 4; ph++) begin
            mode = idle_mode_t'(ph);
            for (int i = 0; i < 435; i++) begin
                if ($urandom_range(3) == 0)
                    pending_x.push_back(IN_W'($urandom()));
                else begin
                    x_lo = $urandom_range(450000);
                    pending_x.push_back(IN_W'($urandom_range(1) ? x_lo : -x_lo));
                end
            end
            if (ph == 0) begin
                @(negedge clk);
                hold_off = 300;
            end
            while (pending_x.size() > 0 || arg.valid || erf_expected_q.size() > 0)
                @(posedge clk);
        end

        mode = IDLE_NONE;
        repeat (PIPE_LAT + 25) @(posedge clk);
        $display("Checked %0d erf results over four idling phases, %0d of them saturated.",
                 checked, saturated);
        if (errors == 0)
            $display("tb_erf_approximation_unit: clean");
        else
            $display("tb_erf_approximation_unit: errors");
        $finish;
    end

endmodule
